### rtl/ppr_pkg.sv
// Shared types and constants of the perspective pixel remap core.
// No dependencies; every other file of the block uses this package.
package ppr_pkg;

  localparam int CoefW    = 48;  // coefficient width, signed Q16.32
  localparam int CoordW   = 12;  // pixel coordinate width
  localparam int GrayW    = 8;   // gray value width
  localparam int NumW     = 62;  // numerator / denominator width
  localparam int QuoW     = 13;  // quotient bits kept by the divider
  localparam int IdxW     = 3;   // register index width
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam int DefTargetWidth  = 640;
  localparam int DefTargetHeight = 480;

  localparam logic signed [NumW-1:0] OneQ32 = 62'sh1_0000_0000;
  localparam logic signed [CoefW-1:0] CoefOne = 48'sh1_0000_0000;

  typedef enum logic [IdxW-1:0] {
    REG_HX_COL   = 3'd0,
    REG_HX_ROW   = 3'd1,
    REG_HX_CONST = 3'd2,
    REG_HY_COL   = 3'd3,
    REG_HY_ROW   = 3'd4,
    REG_HY_CONST = 3'd5,
    REG_HW_COL   = 3'd6,
    REG_HW_ROW   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoefW-1:0] hx_col;
    logic signed [CoefW-1:0] hx_row;
    logic signed [CoefW-1:0] hx_const;
    logic signed [CoefW-1:0] hy_col;
    logic signed [CoefW-1:0] hy_row;
    logic signed [CoefW-1:0] hy_const;
    logic signed [CoefW-1:0] hw_col;
    logic signed [CoefW-1:0] hw_row;
  } coef_t;

  // One classified pixel: magnitudes, quotient signs, zero-denominator flag
  typedef struct packed {
    logic [NumW-1:0]  anx;
    logic [NumW-1:0]  any;
    logic [NumW-1:0]  adn;
    logic             negx;
    logic             negy;
    logic             dz;
    logic [GrayW-1:0] gray;
  } job_t;

endpackage

### rtl/ppr_pix_if.sv
// Source pixel channel: valid/ready with column, row and gray value.
// Depends on ppr_pkg.
interface ppr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [ppr_pkg::CoordW-1:0]  src_col;
  logic [ppr_pkg::CoordW-1:0]  src_row;
  logic [ppr_pkg::GrayW-1:0]   gray;

  modport source (output valid, src_col, src_row, gray, input ready);
  modport sink   (input valid, src_col, src_row, gray, output ready);
endinterface

### rtl/ppr_dst_if.sv
// Target pixel channel: valid/ready with target position, gray and range flag.
// Depends on ppr_pkg.
interface ppr_dst_if;
  logic                        valid;
  logic                        ready;
  logic [ppr_pkg::CoordW-1:0]  dest_x;
  logic [ppr_pkg::CoordW-1:0]  dest_y;
  logic [ppr_pkg::GrayW-1:0]   gray_out;
  logic                        in_range;

  modport source (output valid, dest_x, dest_y, gray_out, in_range, input ready);
  modport sink   (input valid, dest_x, dest_y, gray_out, in_range, output ready);
endinterface

### rtl/ppr_front.sv
// Front part: accepts pixels, evaluates the homography numerators and the
// denominator, and classifies them into magnitudes and signs. Uses ppr_pkg.
module ppr_front (
  input  logic              clk,
  input  logic              rst,
  ppr_pix_if.sink           pix,
  input  ppr_pkg::coef_t    coef,
  output logic              job_valid,
  input  logic              job_ready,
  output ppr_pkg::job_t     job
);

  localparam int ProdW = ppr_pkg::CoefW + ppr_pkg::CoordW + 1;

  // stage 1: products
  logic v1;
  logic signed [ProdW-1:0] p_xc, p_xr, p_yc, p_yr, p_wc, p_wr;
  logic [ppr_pkg::GrayW-1:0] g1;
  // stage 2: sums
  logic v2;
  logic signed [ppr_pkg::NumW-1:0] nx, ny, dn;
  logic [ppr_pkg::GrayW-1:0] g2;

  logic rdy1, rdy2, rdy3;
  logic signed [ppr_pkg::CoordW:0] c_s, r_s;

  assign rdy3 = !job_valid || job_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pix.ready = rdy1;

  assign c_s = $signed({1'b0, pix.src_col});
  assign r_s = $signed({1'b0, pix.src_row});

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= pix.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) job_valid <= v2;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rdy1 && pix.valid) begin
      p_xc <= coef.hx_col * c_s;
      p_xr <= coef.hx_row * r_s;
      p_yc <= coef.hy_col * c_s;
      p_yr <= coef.hy_row * r_s;
      p_wc <= coef.hw_col * c_s;
      p_wr <= coef.hw_row * r_s;
      g1   <= pix.gray;
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      nx <= ppr_pkg::NumW'(p_xc) + ppr_pkg::NumW'(p_xr) + ppr_pkg::NumW'(coef.hx_const);
      ny <= ppr_pkg::NumW'(p_yc) + ppr_pkg::NumW'(p_yr) + ppr_pkg::NumW'(coef.hy_const);
      dn <= ppr_pkg::NumW'(p_wc) + ppr_pkg::NumW'(p_wr) + ppr_pkg::OneQ32;
      g2 <= g1;
    end
  end

  // classify: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      job.anx  <= nx[ppr_pkg::NumW-1] ? ppr_pkg::NumW'(-nx) : ppr_pkg::NumW'(nx);
      job.any  <= ny[ppr_pkg::NumW-1] ? ppr_pkg::NumW'(-ny) : ppr_pkg::NumW'(ny);
      job.adn  <= dn[ppr_pkg::NumW-1] ? ppr_pkg::NumW'(-dn) : ppr_pkg::NumW'(dn);
      job.negx <= nx[ppr_pkg::NumW-1] ^ dn[ppr_pkg::NumW-1];
      job.negy <= ny[ppr_pkg::NumW-1] ^ dn[ppr_pkg::NumW-1];
      job.dz   <= (dn == '0);
      job.gray <= g2;
    end
  end

endmodule

### rtl/ppr_queue.sv
// Short queue between the front and back parts.
// Uses ppr_pkg for the entry type and depth.
module ppr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ppr_pkg::job_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ppr_pkg::job_t  pop_data
);

  ppr_pkg::job_t mem [0:ppr_pkg::QueueDepth-1];
  logic [ppr_pkg::QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [ppr_pkg::QueuePtrW:0]   count;
  logic do_push, do_pop;

  assign push_ready = (count != ppr_pkg::QueuePtrW'(0) + (ppr_pkg::QueuePtrW+1)'(ppr_pkg::QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

### rtl/ppr_back.sv
// Back part: pipelined restoring divider for both coordinates, then the
// truncation, centering and range test. Uses ppr_pkg.
module ppr_back #(
  parameter int TARGET_WIDTH  = ppr_pkg::DefTargetWidth,
  parameter int TARGET_HEIGHT = ppr_pkg::DefTargetHeight
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  ppr_pkg::job_t  job,
  ppr_dst_if.source      dst
);

  localparam int QW = ppr_pkg::QuoW;
  localparam int NW = ppr_pkg::NumW;
  localparam int WW = NW + QW;
  localparam logic [QW-1:0] HalfW = QW'(TARGET_WIDTH / 2);
  localparam logic [QW-1:0] SpanW = QW'(TARGET_WIDTH - TARGET_WIDTH / 2);
  localparam logic [QW-1:0] HalfH = QW'(TARGET_HEIGHT / 2);
  localparam logic [QW-1:0] SpanH = QW'(TARGET_HEIGHT - TARGET_HEIGHT / 2);

  typedef struct packed {
    logic [NW-1:0]    rx;
    logic [NW-1:0]    ry;
    logic [NW-1:0]    ad;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
    logic             ovx;
    logic             ovy;
    logic             negx;
    logic             negy;
    logic             dz;
    logic [ppr_pkg::GrayW-1:0] gray;
  } div_t;

  div_t stg     [0:QW];
  div_t stg_next[0:QW];
  logic v   [0:QW];
  logic rdy [0:QW+1];

  // ready ripples back from the output register
  always_comb begin
    rdy[QW+1] = !dst.valid || dst.ready;
    for (int s = QW; s >= 0; s--) rdy[s] = !v[s] || rdy[s+1];
  end
  assign job_ready = rdy[0];

  // divider steps: overflow check, then one quotient bit per stage
  always_comb begin
    logic [WW-1:0] sh;
    stg_next[0].rx   = job.anx;
    stg_next[0].ry   = job.any;
    stg_next[0].ad   = job.adn;
    stg_next[0].qx   = '0;
    stg_next[0].qy   = '0;
    stg_next[0].ovx  = {{QW{1'b0}}, job.anx} >= ({{QW{1'b0}}, job.adn} << QW);
    stg_next[0].ovy  = {{QW{1'b0}}, job.any} >= ({{QW{1'b0}}, job.adn} << QW);
    stg_next[0].negx = job.negx;
    stg_next[0].negy = job.negy;
    stg_next[0].dz   = job.dz;
    stg_next[0].gray = job.gray;
    for (int s = 1; s <= QW; s++) begin
      stg_next[s] = stg[s-1];
      sh = {{QW{1'b0}}, stg[s-1].ad} << (QW - s);
      if ({{QW{1'b0}}, stg[s-1].rx} >= sh) begin
        stg_next[s].rx = stg[s-1].rx - sh[NW-1:0];
        stg_next[s].qx[QW-s] = 1'b1;
      end
      if ({{QW{1'b0}}, stg[s-1].ry} >= sh) begin
        stg_next[s].ry = stg[s-1].ry - sh[NW-1:0];
        stg_next[s].qy[QW-s] = 1'b1;
      end
    end
  end

  // divider stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QW; s++) v[s] <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= job_valid;
      for (int s = 1; s <= QW; s++) if (rdy[s]) v[s] <= v[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && job_valid) stg[0] <= stg_next[0];
    for (int s = 1; s <= QW; s++) if (rdy[s] && v[s-1]) stg[s] <= stg_next[s];
  end

  // truncation toward zero after centering, and range test
  div_t d;
  logic ok_x, ok_y, ok;
  logic [QW:0] tx, ty;
  logic [QW-1:0] xv, yv;

  always_comb begin
    d  = stg[QW];
    tx = {1'b0, d.qx} + (QW+1)'(d.rx != '0);
    ty = {1'b0, d.qy} + (QW+1)'(d.ry != '0);
    if (!d.negx) begin
      ok_x = !d.ovx && (d.qx < SpanW);
      xv   = d.qx + HalfW;
    end else begin
      ok_x = !d.ovx && (d.qx <= HalfW);
      xv   = (tx > {1'b0, HalfW}) ? '0 : HalfW - tx[QW-1:0];
    end
    if (!d.negy) begin
      ok_y = !d.ovy && (d.qy < SpanH);
      yv   = d.qy + HalfH;
    end else begin
      ok_y = !d.ovy && (d.qy <= HalfH);
      yv   = (ty > {1'b0, HalfH}) ? '0 : HalfH - ty[QW-1:0];
    end
    ok = !d.dz && ok_x && ok_y;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (rdy[QW+1]) begin
      dst.valid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[QW+1] && v[QW]) begin
      dst.dest_x   <= ok ? xv[ppr_pkg::CoordW-1:0] : '0;
      dst.dest_y   <= ok ? yv[ppr_pkg::CoordW-1:0] : '0;
      dst.gray_out <= ok ? d.gray : '0;
      dst.in_range <= ok;
    end
  end

endmodule

### rtl/perspective_pixel_remap_core.sv
// Top level of the perspective pixel remap core: coefficient registers,
// front part, queue and back part. Uses ppr_pkg, ppr_pix_if, ppr_dst_if.
//
//  channel | direction | transfer condition     | payload
//  pix     | in        | pix.valid & pix.ready  | src_col, src_row, gray
//  dst     | out       | dst.valid & dst.ready  | dest_x, dest_y, gray_out, in_range
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// One pixel per cycle while dst takes results; a pixel passes 3 front stages, the
// queue, 14 divider stages (overflow test, then quotient bits) and output register.
// Reset (rst, synchronous) loads the identity homography and empties the
// pipeline and queue. A stall at dst backs up the divider; the queue lets
// the front keep taking pixels until it fills.
module perspective_pixel_remap_core #(
  parameter int TARGET_WIDTH  = ppr_pkg::DefTargetWidth,
  parameter int TARGET_HEIGHT = ppr_pkg::DefTargetHeight
) (
  input  logic                       clk,
  input  logic                       rst,
  ppr_pix_if.sink                    pix,
  ppr_dst_if.source                  dst,
  input  logic                       cfg_we,
  input  logic [ppr_pkg::IdxW-1:0]   cfg_index,
  input  logic [ppr_pkg::CoefW-1:0]  cfg_data
);

  ppr_pkg::coef_t coef;
  ppr_pkg::job_t  f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.hx_col   <= ppr_pkg::CoefOne;
      coef.hx_row   <= '0;
      coef.hx_const <= '0;
      coef.hy_col   <= '0;
      coef.hy_row   <= ppr_pkg::CoefOne;
      coef.hy_const <= '0;
      coef.hw_col   <= '0;
      coef.hw_row   <= '0;
    end else if (cfg_we) begin
      case (ppr_pkg::reg_idx_t'(cfg_index))
        ppr_pkg::REG_HX_COL:   coef.hx_col   <= $signed(cfg_data);
        ppr_pkg::REG_HX_ROW:   coef.hx_row   <= $signed(cfg_data);
        ppr_pkg::REG_HX_CONST: coef.hx_const <= $signed(cfg_data);
        ppr_pkg::REG_HY_COL:   coef.hy_col   <= $signed(cfg_data);
        ppr_pkg::REG_HY_ROW:   coef.hy_row   <= $signed(cfg_data);
        ppr_pkg::REG_HY_CONST: coef.hy_const <= $signed(cfg_data);
        ppr_pkg::REG_HW_COL:   coef.hw_col   <= $signed(cfg_data);
        ppr_pkg::REG_HW_ROW:   coef.hw_row   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  ppr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .coef      (coef),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  ppr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_job)
  );

  ppr_back #(
    .TARGET_WIDTH  (TARGET_WIDTH),
    .TARGET_HEIGHT (TARGET_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .dst       (dst)
  );

endmodule

### bench/perspective_pixel_remap_core_test.sv
// Testbench for perspective_pixel_remap_core: directed pixels, then random homographies
// and pixels, checked against a behavioral remap predictor. Uses ppr_pkg, ppr_pix_if, ppr_dst_if.
`timescale 1ns / 1ps

module perspective_pixel_remap_core_test;

  localparam int TgtW = ppr_pkg::DefTargetWidth;
  localparam int TgtH = ppr_pkg::DefTargetHeight;
  localparam int DrainCycles = 30;
  localparam int WatchdogLimit = 20000;
  localparam int LongHold = 300;

  typedef struct {
    logic [ppr_pkg::CoordW-1:0] x;
    logic [ppr_pkg::CoordW-1:0] y;
    logic [ppr_pkg::GrayW-1:0]  g;
    logic                       ok;
  } dst_pixel_t;

  typedef struct {
    int              grp;      // 0: reset homography, 1: zero-denominator setup
    int              col;
    int              row;
    int              g;
    bit              typed;
    dst_pixel_t      want;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ppr_pkg::IdxW-1:0] cfg_index = '0;
  logic [ppr_pkg::CoefW-1:0] cfg_data = '0;

  ppr_pix_if pix ();
  ppr_dst_if dst ();

  perspective_pixel_remap_core dut (
    .clk(clk), .rst(rst), .pix(pix.sink), .dst(dst.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  longint     coef [8];
  dst_pixel_t expected_pixels [$];
  int         errors = 0;
  int         sent = 0;
  int         received = 0;
  int         in_range_seen = 0;
  int         src_idle_pct = 28;
  int         dst_idle_pct = 60;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  // Exact truncation toward zero of n/d + h
  function automatic longint trunc_offset(longint n, longint d, longint h);
    longint unsigned an, ad, qm, rm;
    longint fl;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    qm = an / ad;
    rm = an % ad;
    fl = ((n < 0) != (d < 0)) ? -longint'(qm) - (rm != 0) : longint'(qm);
    if (fl + h >= 0) return fl + h;
    return fl + (rm != 0) + h;
  endfunction

  function automatic dst_pixel_t remap_pixel(int col, int row, int g);
    dst_pixel_t p;
    longint nx, ny, dn, x, y;
    nx = coef[ppr_pkg::REG_HX_COL] * col + coef[ppr_pkg::REG_HX_ROW] * row
       + coef[ppr_pkg::REG_HX_CONST];
    ny = coef[ppr_pkg::REG_HY_COL] * col + coef[ppr_pkg::REG_HY_ROW] * row
       + coef[ppr_pkg::REG_HY_CONST];
    dn = coef[ppr_pkg::REG_HW_COL] * col + coef[ppr_pkg::REG_HW_ROW] * row
       + 64'sd4294967296;
    p = '{x: '0, y: '0, g: '0, ok: 1'b0};
    if (dn != 0) begin
      x = trunc_offset(nx, dn, TgtW / 2);
      y = trunc_offset(ny, dn, TgtH / 2);
      if (x >= 0 && x < TgtW && y >= 0 && y < TgtH) begin
        p = '{x: x[ppr_pkg::CoordW-1:0], y: y[ppr_pkg::CoordW-1:0],
              g: g[ppr_pkg::GrayW-1:0], ok: 1'b1};
      end
    end
    return p;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", received, what, got, want);
    errors++;
  endtask

  // Register write, only with the pipeline drained
  task automatic write_coef(ppr_pkg::reg_idx_t idx, longint value);
    logic signed [ppr_pkg::CoefW-1:0] v;
    v = value[ppr_pkg::CoefW-1:0];
    pix.valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    coef[idx] = longint'(v);
  endtask

  // Offer one pixel; push its expectation on transfer
  task automatic send_pixel(int col, int row, int g, bit typed, dst_pixel_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.src_col <= col[ppr_pkg::CoordW-1:0];
    pix.src_row <= row[ppr_pkg::CoordW-1:0];
    pix.gray <= g[ppr_pkg::GrayW-1:0];
    do @(posedge clk); while (!pix.ready);
    expected_pixels.push_back(typed ? want : remap_pixel(col, row, g));
    sent++;
    if (sent == 400) hold_req = 1'b1;
    if (sent == 600) begin
      src_idle_pct = 60;
      dst_idle_pct = 28;
    end
    if (sent == 1200) begin
      src_idle_pct = 0;
      dst_idle_pct = 0;
    end
  endtask

  // Receiver readiness with one long hold-off
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= LongHold;
      hold_req = 1'b0;
      dst.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      dst.ready <= 1'b0;
    end else begin
      dst.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    dst_pixel_t w;
    if (!rst && dst.valid && dst.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("unexpected result at x %0d y %0d", dst.dest_x, dst.dest_y);
        errors++;
      end else begin
        w = expected_pixels.pop_front();
        if (dst.dest_x !== w.x) report("dest_x", dst.dest_x, w.x);
        if (dst.dest_y !== w.y) report("dest_y", dst.dest_y, w.y);
        if (dst.gray_out !== w.g) report("gray_out", dst.gray_out, w.g);
        if (dst.in_range !== w.ok) report("in_range", dst.in_range, w.ok);
        in_range_seen += w.ok;
      end
      received++;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (dst.valid && dst.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: %0d results outstanding", expected_pixels.size());
      $display("perspective_pixel_remap_core test failed");
      $finish;
    end
  end

  function automatic longint rand_full();
    return longint'($signed({$urandom(), $urandom()} << 16)) >>> 16;
  endfunction

  // Coefficient of magnitude below 2^span_bits units of 1.0 / 2^32, with random sign
  function automatic longint rand_scaled(int span_bits);
    longint v;
    v = longint'({$urandom(), $urandom()}) & ((64'sd1 << span_bits) - 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic int rand_coord(int lim);
    return ($urandom_range(9) < 2) ? $urandom_range(4095) : $urandom_range(lim);
  endfunction

  initial begin
    pixel_row_t table_rows [$];
    dst_pixel_t none;
    int col, row;
    none = '{x: '0, y: '0, g: '0, ok: 1'b0};
    pix.valid = 1'b0;
    pix.src_col = '0;
    pix.src_row = '0;
    pix.gray = '0;
    dst.ready = 1'b0;
    coef = '{64'sd4294967296, 0, 0, 0, 64'sd4294967296, 0, 0, 0};

    // Identity after reset: x = col + 320, y = row + 240
    table_rows = '{
      '{0, 0, 0, 0, 1, '{12'd320, 12'd240, 8'd0, 1'b1}},
      '{0, 319, 239, 255, 1, '{12'd639, 12'd479, 8'd255, 1'b1}},
      '{0, 320, 0, 5, 1, '{12'd0, 12'd0, 8'd0, 1'b0}},
      '{0, 0, 240, 7, 1, '{12'd0, 12'd0, 8'd0, 1'b0}},
      '{0, 4095, 4095, 255, 1, '{12'd0, 12'd0, 8'd0, 1'b0}},
      '{0, 170, 85, 170, 1, '{12'd490, 12'd325, 8'd170, 1'b1}},
      '{0, 85, 170, 85, 1, '{12'd405, 12'd410, 8'd85, 1'b1}},
      '{0, 2730, 1365, 1, 1, '{12'd0, 12'd0, 8'd0, 1'b0}},
      '{0, 1365, 2730, 128, 1, '{12'd0, 12'd0, 8'd0, 1'b0}},
      // hw_col = -1.0: denominator zero at column one
      '{1, 1, 5, 9, 1, '{12'd0, 12'd0, 8'd0, 1'b0}},
      '{1, 1, 4095, 255, 1, '{12'd0, 12'd0, 8'd0, 1'b0}},
      '{1, 2, 0, 33, 0, none},
      '{1, 0, 100, 44, 0, none},
      '{1, 3, 7, 200, 0, none}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].grp == 1 && coef[ppr_pkg::REG_HW_COL] == 0)
        write_coef(ppr_pkg::REG_HW_COL, -64'sd4294967296);
      send_pixel(table_rows[i].col, table_rows[i].row, table_rows[i].g,
                 table_rows[i].typed, table_rows[i].want);
    end

    // Small negative value truncates to column zero: x = -320.5 + 320
    write_coef(ppr_pkg::REG_HW_COL, 0);
    write_coef(ppr_pkg::REG_HX_COL, 0);
    write_coef(ppr_pkg::REG_HX_CONST, -64'sd1376537018368);
    send_pixel(10, 10, 77, 0, none);
    send_pixel(4095, 0, 1, 0, none);

    // Coefficient extremes, all positive then all negative
    for (int e = 0; e < 2; e++) begin
      for (int k = 0; k < 8; k++)
        write_coef(ppr_pkg::reg_idx_t'(k),
                   e ? -64'sd140737488355328 : 64'sd140737488355327);
      repeat (20) send_pixel(rand_coord(4095), rand_coord(4095), $urandom_range(255), 0, none);
    end

    // Random homographies: most near plausible ground-plane maps
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        for (int k = 0; k < 8; k++) write_coef(ppr_pkg::reg_idx_t'(k), rand_full());
      end else begin
        write_coef(ppr_pkg::REG_HX_COL, rand_scaled(34));
        write_coef(ppr_pkg::REG_HX_ROW, rand_scaled(32));
        write_coef(ppr_pkg::REG_HX_CONST, rand_scaled(41));
        write_coef(ppr_pkg::REG_HY_COL, rand_scaled(32));
        write_coef(ppr_pkg::REG_HY_ROW, rand_scaled(34));
        write_coef(ppr_pkg::REG_HY_CONST, rand_scaled(41));
        write_coef(ppr_pkg::REG_HW_COL, rand_scaled(ph == 5 ? 20 : 21));
        write_coef(ppr_pkg::REG_HW_ROW, rand_scaled(ph == 6 ? 47 : 21));
      end
      repeat (205) begin
        col = rand_coord(700);
        row = rand_coord(500);
        send_pixel(col, row, $urandom_range(255), 0, none);
      end
    end
    pix.valid <= 1'b0;

    wait (expected_pixels.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("%0d pixels remapped over reset, zero-denominator, extreme and random",
             received);
    $display("homographies; %0d landed inside the target, with long output stalls",
             in_range_seen);
    if (errors == 0) begin
      $display("perspective_pixel_remap_core test passed");
    end else begin
      $display("perspective_pixel_remap_core test failed");
    end
    $finish;
  end

endmodule
